### rtl/gmec_pkg.sv
`default_nettype none
package gmec_pkg;

  typedef struct packed {
    logic [30:0] rho_old;
    logic [30:0] rho_new;
    logic signed [31:0] mom_x_in;
    logic signed [31:0] mom_y_in;
    logic signed [31:0] mom_z_in;
    logic signed [31:0] energy_in;
    logic signed [31:0] field_gx;
    logic signed [31:0] field_gy;
    logic signed [31:0] field_gz;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mom_x_out;
    logic signed [31:0] mom_y_out;
    logic signed [31:0] mom_z_out;
    logic signed [31:0] energy_out;
    logic bad_density;
  } out_t;

  typedef enum logic [2:0] {
    REG_TIME_STEP   = 3'd0,
    REG_USE_FIELD   = 3'd1,
    REG_THREE_D     = 3'd2,
    REG_GRAVITY_X   = 3'd3,
    REG_GRAVITY_Y   = 3'd4,
    REG_GRAVITY_Z   = 3'd5
  } reg_idx_e;

  // quotient bits kept by the divider; larger results saturate
  localparam int QuoBits = 34;
  localparam logic [QuoBits-1:0] SatCap = QuoBits'(1) << 33;

  typedef struct packed {
    logic bad;
    logic neg;
    logic sat;
    logic [2:0][31:0] mo;
    logic [31:0] e;
  } meta_t;

endpackage
`default_nettype wire

### rtl/gmec_div.sv
`default_nettype none
module gmec_div
  import gmec_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [64:0] num_i,
  input  wire logic [31:0] den_i,
  input  wire meta_t       meta_i,
  output logic             valid_o,
  output logic [QuoBits-1:0] quo_o,
  output meta_t            meta_o
);

  // two quotient bits per stage
  localparam int NStg = QuoBits / 2;

  logic [NStg-1:0]    v_q;
  logic [31:0]        rem_q [NStg];
  logic [QuoBits-1:0] quo_q [NStg];
  logic [QuoBits-1:0] lo_q  [NStg];
  logic [31:0]        den_q [NStg];
  meta_t              meta_q [NStg];

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic               v_in;
    logic [31:0]        rem_in;
    logic [QuoBits-1:0] quo_in;
    logic [QuoBits-1:0] lo_in;
    logic [31:0]        den_in;
    meta_t              meta_in;
    logic [31:0]        rem_d;
    logic [QuoBits-1:0] quo_d;

    if (k == 0) begin : g_first
      // top bits are below the divisor once the overflow check passed
      assign v_in    = valid_i;
      assign rem_in  = {1'b0, num_i[64:QuoBits]};
      assign quo_in  = '0;
      assign lo_in   = num_i[QuoBits-1:0];
      assign den_in  = den_i;
      assign meta_in = meta_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign den_in  = den_q[k-1];
      assign meta_in = meta_q[k-1];
    end

    always_comb begin
      logic [32:0] r;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int b = 0; b < 2; b++) begin
        r = {rem_d, lo_in[QuoBits-1-b]};
        if (r >= {1'b0, den_in}) begin
          r = r - {1'b0, den_in};
          quo_d = {quo_d[QuoBits-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QuoBits-2:0], 1'b0};
        end
        rem_d = r[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        lo_q[k]   <= {lo_in[QuoBits-3:0], 2'b00};
        den_q[k]  <= den_in;
        meta_q[k] <= meta_in;
      end
    end
  end

  assign valid_o = v_q[NStg-1];
  assign quo_o   = quo_q[NStg-1];
  assign meta_o  = meta_q[NStg-1];

endmodule
`default_nettype wire

### rtl/gravity_momentum_energy_correction.sv
`default_nettype none
// channel   | direction | signals
// input     | in        | in_valid_i, in_stall_o, in_i
// output    | out       | out_valid_o, out_stall_i, out_o
// config    | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// one cell per cycle unless the output stalls; 7 arithmetic stages, 17 divider
// stages of two quotient bits each, and an output register
// reset clears the valid bits and sets the configuration registers to their defaults
// a stall on the output while out_valid_o is high freezes the whole pipeline; in_stall_o follows it
module gravity_momentum_energy_correction
  import gmec_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int Shift = 2 * FRAC_BITS + 1;
  localparam logic [95:0] Rnd = 96'(1) << (Shift - 1);

  typedef struct packed {
    logic bad;
    logic [2:0] act;
    logic [2:0][31:0] m;
    logic [31:0] e;
    logic [30:0] rho;
  } car_t;

  // configuration
  logic [30:0] dt_q;
  logic        field_q, three_q;
  logic [2:0][31:0] g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= '0;
      field_q <= 1'b0;
      three_q <= 1'b1;
      g_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIME_STEP: dt_q    <= cfg_data_i[30:0];
        REG_USE_FIELD: field_q <= cfg_data_i[0];
        REG_THREE_D:   three_q <= cfg_data_i[0];
        REG_GRAVITY_X: g_q[0]  <= cfg_data_i;
        REG_GRAVITY_Y: g_q[1]  <= cfg_data_i;
        REG_GRAVITY_Z: g_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [7:1] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:1], in_valid_i};
    end
  end

  // stage 1: gravity select, dt * |g|
  car_t c1_d, c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [2:0][62:0] p1_d, p1_q;
  logic [2:0]       gneg_d, gneg_q, gneg2_q, gneg3_q;
  logic [31:0]      rsum_d, rsum_q;

  always_comb begin
    logic [2:0][31:0] g;
    logic [31:0] ga;
    g = field_q ? {in_i.field_gz, in_i.field_gy, in_i.field_gx} : g_q;
    for (int i = 0; i < 3; i++) begin
      gneg_d[i] = g[i][31];
      ga = g[i][31] ? (32'd0 - g[i]) : g[i];
      p1_d[i] = 63'({32'd0, dt_q} * {31'd0, ga});
    end
    rsum_d   = {1'b0, in_i.rho_old} + {1'b0, in_i.rho_new};
    c1_d.bad = (in_i.rho_new == '0);
    c1_d.act = {three_q, 2'b11};
    c1_d.m   = {in_i.mom_z_in, in_i.mom_y_in, in_i.mom_x_in};
    c1_d.e   = in_i.energy_in;
    c1_d.rho = in_i.rho_new;
  end

  // stage 2: partial products of (dt*|g|) * rsum
  logic [2:0][63:0] pl_d, pl_q;
  logic [2:0][62:0] ph_d, ph_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pl_d[i] = {32'd0, p1_q[i][31:0]} * {32'd0, rsum_q};
      ph_d[i] = 63'({33'd0, p1_q[i][62:32]} * {32'd0, rsum_q});
    end
  end

  // stage 3: combine, round, shift, clamp
  logic [2:0][QuoBits-1:0] dm_d, dm_q;

  always_comb begin
    logic [95:0] full;
    logic [95:0] sh;
    for (int i = 0; i < 3; i++) begin
      full = {32'd0, pl_q[i]} + ({33'd0, ph_q[i]} << 32) + Rnd;
      sh   = full >> Shift;
      dm_d[i] = (sh > {62'd0, SatCap}) ? SatCap : sh[QuoBits-1:0];
    end
  end

  // stage 4: momentum update with saturation
  logic [2:0][31:0] mo_d, mo_q;

  always_comb begin
    logic signed [35:0] s;
    for (int i = 0; i < 3; i++) begin
      s = gneg3_q[i] ? (36'(signed'(c3_q.m[i])) - {2'b00, dm_q[i]})
                     : (36'(signed'(c3_q.m[i])) + {2'b00, dm_q[i]});
      if (c3_q.bad || !c3_q.act[i]) mo_d[i] = c3_q.m[i];
      else if (s > 36'sd2147483647) mo_d[i] = 32'h7fff_ffff;
      else if (s < -36'sd2147483648) mo_d[i] = 32'h8000_0000;
      else mo_d[i] = s[31:0];
    end
  end

  // stage 5: squares
  logic [2:0][63:0] sqo_d, sqo_q, sqn_d, sqn_q;
  logic [2:0][31:0] mo5_q;

  always_comb begin
    logic [31:0] a, b;
    for (int i = 0; i < 3; i++) begin
      a = c4_q.m[i][31] ? (32'd0 - c4_q.m[i]) : c4_q.m[i];
      b = mo_q[i][31] ? (32'd0 - mo_q[i]) : mo_q[i];
      sqo_d[i] = c4_q.act[i] ? {32'd0, a} * {32'd0, a} : '0;
      sqn_d[i] = c4_q.act[i] ? {32'd0, b} * {32'd0, b} : '0;
    end
  end

  // stage 6: sums of squares
  logic [63:0] so_d, so_q, sn_d, sn_q;
  logic [2:0][31:0] mo6_q;

  assign so_d = sqo_q[0] + sqo_q[1] + sqo_q[2];
  assign sn_d = sqn_q[0] + sqn_q[1] + sqn_q[2];

  // stage 7: difference, rounding offset, overflow check
  logic [64:0] num_d, num_q;
  logic [31:0] den_d, den_q;
  meta_t       meta_d, meta_q;

  always_comb begin
    logic [63:0] d;
    d = (sn_q >= so_q) ? (sn_q - so_q) : (so_q - sn_q);
    num_d = {1'b0, d} + {34'd0, c6_q.rho};
    den_d = {c6_q.rho, 1'b0};
    meta_d.bad = c6_q.bad;
    meta_d.neg = (sn_q < so_q);
    meta_d.sat = ({1'b0, num_d[64:QuoBits]} >= den_d);
    meta_d.mo  = mo6_q;
    meta_d.e   = c6_q.e;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= c1_d;
      p1_q    <= p1_d;
      gneg_q  <= gneg_d;
      rsum_q  <= rsum_d;
      c2_q    <= c1_q;
      gneg2_q <= gneg_q;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      c3_q    <= c2_q;
      gneg3_q <= gneg2_q;
      dm_q    <= dm_d;
      c4_q    <= c3_q;
      mo_q    <= mo_d;
      c5_q    <= c4_q;
      mo5_q   <= mo_q;
      sqo_q   <= sqo_d;
      sqn_q   <= sqn_d;
      c6_q    <= c5_q;
      mo6_q   <= mo5_q;
      so_q    <= so_d;
      sn_q    <= sn_d;
      num_q   <= num_d;
      den_q   <= den_d;
      meta_q  <= meta_d;
    end
  end

  // divider; the bad-density case gives a dummy divisor, result ignored
  logic               dv_v;
  logic [QuoBits-1:0] dv_quo;
  meta_t              dv_meta;

  gmec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[7]),
    .num_i   (num_q),
    .den_i   (den_q),
    .meta_i  (meta_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .meta_o  (dv_meta)
  );

  // output stage: energy update
  out_t out_d, out_q;
  logic out_v_q;

  always_comb begin
    logic [QuoBits-1:0] q;
    logic signed [36:0] s;
    q = (dv_meta.sat || dv_quo > SatCap) ? SatCap : dv_quo;
    s = dv_meta.neg ? (37'(signed'(dv_meta.e)) - {3'b000, q})
                    : (37'(signed'(dv_meta.e)) + {3'b000, q});
    out_d.mom_x_out   = dv_meta.mo[0];
    out_d.mom_y_out   = dv_meta.mo[1];
    out_d.mom_z_out   = dv_meta.mo[2];
    out_d.bad_density = dv_meta.bad;
    if (dv_meta.bad) out_d.energy_out = dv_meta.e;
    else if (s > 37'sd2147483647) out_d.energy_out = 32'h7fff_ffff;
    else if (s < -37'sd2147483648) out_d.energy_out = 32'h8000_0000;
    else out_d.energy_out = s[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import gmec_pkg::*;

  localparam int FracBits = 16;
  localparam int Latency = 25;
  localparam longint CycleLimit = 400000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;

  gravity_momentum_energy_correction dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // shadow of the block's registers
  logic [30:0] dt_q;
  logic field_q, three_d_q;
  logic signed [31:0] grav_q [3];

  in_t pending_cells [$];
  out_t expected_cells [$];
  int errors;
  longint cycles;
  bit hold_off;
  int send_wait, recv_wait;
  // input transaction taken at the last rising edge
  logic in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_t correct_cell(in_t c);
    out_t r;
    logic signed [31:0] m [3];
    logic signed [31:0] g [3];
    logic signed [31:0] mo [3];
    logic [127:0] prod, mag;
    logic [127:0] s_old, s_new, diff, q, rm, den;
    logic [63:0] ga, ma;
    longint signed delta, inc;
    int n;
    m[0] = c.mom_x_in; m[1] = c.mom_y_in; m[2] = c.mom_z_in;
    g[0] = field_q ? c.field_gx : grav_q[0];
    g[1] = field_q ? c.field_gy : grav_q[1];
    g[2] = field_q ? c.field_gz : grav_q[2];
    mo = m;
    r.bad_density = 1'b0;
    r.energy_out = c.energy_in;
    if (c.rho_new == 0) begin
      r.bad_density = 1'b1;
    end else begin
      n = three_d_q ? 3 : 2;
      s_old = 0; s_new = 0;
      for (int i = 0; i < n; i++) begin
        ga = g[i] < 0 ? -64'(longint'(g[i])) : 64'(longint'(g[i]));
        prod = 128'(dt_q) * 128'(ga) * (128'(c.rho_old) + 128'(c.rho_new));
        mag = (prod + (128'd1 << (2 * FracBits))) >> (2 * FracBits + 1);
        if (mag > (128'd1 << 33)) mag = 128'd1 << 33;
        delta = g[i] < 0 ? -longint'(mag[63:0]) : longint'(mag[63:0]);
        mo[i] = sat32(longint'(m[i]) + delta);
        ma = m[i] < 0 ? -64'(longint'(m[i])) : 64'(longint'(m[i]));
        s_old += 128'(ma) * 128'(ma);
        ma = mo[i] < 0 ? -64'(longint'(mo[i])) : 64'(longint'(mo[i]));
        s_new += 128'(ma) * 128'(ma);
      end
      den = 128'(c.rho_new) * 2;
      diff = s_new >= s_old ? s_new - s_old : s_old - s_new;
      q = diff / den;
      rm = diff % den;
      if (rm >= 128'(c.rho_new)) q++;
      if (q > (128'd1 << 33)) q = 128'd1 << 33;
      inc = s_new >= s_old ? longint'(q[63:0]) : -longint'(q[63:0]);
      r.energy_out = sat32(longint'(c.energy_in) + inc);
    end
    r.mom_x_out = mo[0]; r.mom_y_out = mo[1]; r.mom_z_out = mo[2];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_cells.size() > 0 && send_wait == 0) begin
          in_data <= pending_cells.pop_front();
          in_valid <= 1'b1;
          send_wait <= $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
          if (send_wait > 0) send_wait <= send_wait - 1;
        end
      end
    end
  end

  // predictor runs at acceptance so register writes line up
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_cells.push_back(correct_cell(in_data));
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      recv_wait = $urandom_range(0, 5);
      out_stall <= recv_wait != 0;
    end else if (out_stall) begin
      if (recv_wait > 0) recv_wait--;
      out_stall <= recv_wait != 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, out_data);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        if (e.mom_x_out !== out_data.mom_x_out)
          $display("%0t: mom_x exp %h got %h", $time, e.mom_x_out, out_data.mom_x_out);
        if (e.mom_y_out !== out_data.mom_y_out)
          $display("%0t: mom_y exp %h got %h", $time, e.mom_y_out, out_data.mom_y_out);
        if (e.mom_z_out !== out_data.mom_z_out)
          $display("%0t: mom_z exp %h got %h", $time, e.mom_z_out, out_data.mom_z_out);
        if (e.energy_out !== out_data.energy_out)
          $display("%0t: energy exp %h got %h", $time, e.energy_out, out_data.energy_out);
        if (e.bad_density !== out_data.bad_density)
          $display("%0t: bad_density exp %b got %b", $time, e.bad_density,
                   out_data.bad_density);
        if (e !== out_data) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    case (idx)
      REG_TIME_STEP: dt_q = v[30:0];
      REG_USE_FIELD: field_q = v[0];
      REG_THREE_D:   three_d_q = v[0];
      REG_GRAVITY_X: grav_q[0] = v;
      REG_GRAVITY_Y: grav_q[1] = v;
      REG_GRAVITY_Z: grav_q[2] = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cells.size() > 0 || in_valid || expected_cells.size() > 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word(int mode);
    case (mode)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h7ffff) : -$urandom_range(0, 32'h7ffff);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_t rnd_cell();
    in_t c;
    c.rho_old = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h3ffff));
    c.rho_new = $urandom_range(0, 15) == 0 ? 31'd0 :
                ($urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(1, 32'h3ffff)));
    c.mom_x_in = rnd_word($urandom_range(0, 9));
    c.mom_y_in = rnd_word($urandom_range(0, 9));
    c.mom_z_in = rnd_word($urandom_range(0, 9));
    c.energy_in = rnd_word($urandom_range(0, 9));
    c.field_gx = rnd_word($urandom_range(2, 3));
    c.field_gy = rnd_word($urandom_range(2, 3));
    c.field_gz = rnd_word($urandom_range(2, 3));
    return c;
  endfunction

  task automatic set_mode(logic [30:0] dt, bit fld, bit d3);
    write_reg(REG_TIME_STEP, {1'b0, dt});
    write_reg(REG_USE_FIELD, {31'd0, fld});
    write_reg(REG_THREE_D, {31'd0, d3});
    write_reg(REG_GRAVITY_X, rnd_word($urandom_range(0, 3)));
    write_reg(REG_GRAVITY_Y, rnd_word($urandom_range(0, 3)));
    write_reg(REG_GRAVITY_Z, rnd_word($urandom_range(0, 3)));
  endtask

  initial begin
    in_t c;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_idx = REG_TIME_STEP; cfg_data = '0;
    errors = 0; cycles = 0; hold_off = 1'b0; send_wait = 0; recv_wait = 0;
    dt_q = '0; field_q = 1'b0; three_d_q = 1'b1; grav_q = '{default: '0};
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: extremes, zero density, both modes
    set_mode(31'h7fffffff, 1'b0, 1'b1);
    write_reg(REG_GRAVITY_X, 32'h7fffffff);
    write_reg(REG_GRAVITY_Y, 32'h80000000);
    write_reg(REG_GRAVITY_Z, 32'h00010000);
    c = '0; pending_cells.push_back(c);
    c = '1; pending_cells.push_back(c);
    c.rho_new = 0; pending_cells.push_back(c);
    c = '0; c.rho_new = 1; c.mom_x_in = 32'sh7fffffff; c.mom_y_in = 32'sh80000000;
    c.energy_in = 32'sh7fffffff; pending_cells.push_back(c);
    c.rho_old = 31'h7fffffff; c.rho_new = 31'h7fffffff; c.energy_in = 32'sh80000000;
    pending_cells.push_back(c);
    for (int i = 0; i < 5; i++) pending_cells.push_back(rnd_cell());
    drain();
    set_mode(31'h00010000, 1'b1, 1'b0);
    for (int i = 0; i < 10; i++) pending_cells.push_back(rnd_cell());
    drain();

    // random phases, one with a long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph == 0 ? 31'd0 : (ph == 5 ? 31'h7fffffff : 31'($urandom_range(1, 32'h3ffff))),
               ph[0], ph[1]);
      for (int i = 0; i < 90; i++) pending_cells.push_back(rnd_cell());
      if (ph == 2) begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
